FILE: rtl/nsf_pkg.sv
// ---------------------------------------------------------------------------
// nsf_pkg
// Shared types, codes and helper functions for the NMEA sentence framer.
// ---------------------------------------------------------------------------
package nsf_pkg;

  localparam int TERM_CHARS_DEF  = 15;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int NAME_LEN        = 5;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_FIX    = 8'h41;

  localparam logic [2:0] ST_NONE = 3'd0;
  localparam logic [2:0] ST_RMC  = 3'd1;
  localparam logic [2:0] ST_GGA  = 3'd2;
  localparam logic [2:0] ST_GSV  = 3'd3;
  localparam logic [2:0] ST_VTG  = 3'd4;
  localparam logic [2:0] ST_GSA  = 3'd5;
  localparam logic [2:0] ST_GLL  = 3'd6;
  localparam logic [2:0] ST_FAIL = 3'd7;

  localparam logic [2:0] CL_BODY  = 3'd0;
  localparam logic [2:0] CL_COMMA = 3'd1;
  localparam logic [2:0] CL_STAR  = 3'd2;
  localparam logic [2:0] CL_EOL   = 3'd3;
  localparam logic [2:0] CL_START = 3'd4;

  typedef logic [0:NAME_LEN-1][7:0] name_t;

  typedef struct packed {
    logic [2:0] cls;
    logic [7:0] ch;
  } item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  function automatic logic [7:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    if (c inside {[8'h41:8'h46]}) begin
      v = c - 8'h37;
    end else if (c inside {[8'h61:8'h66]}) begin
      v = c - 8'h57;
    end else begin
      v = c - CH_ZERO;
    end
    return v;
  endfunction

  function automatic logic [2:0] name_kind(input name_t n);
    logic [2:0] k;
    case (n)
      name_t'("GPRMC"), name_t'("GNRMC"): k = ST_RMC;
      name_t'("GPGGA"), name_t'("GNGGA"): k = ST_GGA;
      name_t'("GPGSV"): k = ST_GSV;
      name_t'("GPVTG"): k = ST_VTG;
      name_t'("GPGSA"): k = ST_GSA;
      name_t'("GPGLL"): k = ST_GLL;
      default: k = ST_NONE;
    endcase
    return k;
  endfunction

endpackage

FILE: rtl/nsf_front.sv
// ---------------------------------------------------------------------------
// nsf_front
// Accepts incoming characters and tags each with its framing class.
// ---------------------------------------------------------------------------
module nsf_front (
  input  logic                 in_push,
  input  logic [7:0]           in_ch,
  input  nsf_pkg::q_stat_t     q_stat,
  output logic                 in_full,
  output logic                 q_push,
  output nsf_pkg::item_t       q_item
);

  logic [2:0] cls;

  always_comb begin
    case (in_ch)
      nsf_pkg::CH_COMMA:           cls = nsf_pkg::CL_COMMA;
      nsf_pkg::CH_STAR:            cls = nsf_pkg::CL_STAR;
      nsf_pkg::CH_CR, nsf_pkg::CH_LF: cls = nsf_pkg::CL_EOL;
      nsf_pkg::CH_DOLLAR:          cls = nsf_pkg::CL_START;
      default:                     cls = nsf_pkg::CL_BODY;
    endcase
  end

  assign in_full     = q_stat.full;
  assign q_push      = in_push && !q_stat.full;
  assign q_item.cls  = cls;
  assign q_item.ch   = in_ch;

endmodule

FILE: rtl/nsf_queue.sv
// ---------------------------------------------------------------------------
// nsf_queue
// Short register queue between the front and back parts.
// ---------------------------------------------------------------------------
module nsf_queue #(
  parameter int WIDTH = $bits(nsf_pkg::item_t),
  parameter int DEPTH = nsf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              pop,
  output logic [WIDTH-1:0]  rd_data,
  output nsf_pkg::q_stat_t  q_stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign q_stat.empty = (cnt_r == '0);
  assign q_stat.full  = (cnt_r == CW'(DEPTH));
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign rd_data      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

FILE: rtl/nsf_back.sv
// ---------------------------------------------------------------------------
// nsf_back
// Carries out framing, checksum and fix tracking; holds the result slot.
// ---------------------------------------------------------------------------
module nsf_back #(
  parameter int TERM_CHARS = nsf_pkg::TERM_CHARS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  nsf_pkg::q_stat_t  q_stat,
  input  nsf_pkg::item_t    q_item,
  output logic              q_pop,
  input  logic              out_pop,
  output logic              out_empty,
  output logic [2:0]        out_status,
  output logic              out_has_fix,
  output logic [31:0]       out_passed_count,
  output logic [31:0]       out_failed_count,
  output logic [31:0]       out_fix_count,
  output logic [31:0]       out_char_count
);

  localparam int FW = $clog2(TERM_CHARS);

  logic [7:0]      xor_r, xor_nxt;
  logic            cs_r, cs_nxt;
  logic [2:0]      kind_r, kind_nxt;
  logic [7:0]      idx_r, idx_nxt;
  logic [FW-1:0]   fill_r, fill_nxt;
  nsf_pkg::name_t  chars_r, chars_nxt;
  logic            fix_r, fix_nxt;
  logic [31:0]     pass_r, pass_nxt;
  logic [31:0]     fail_r, fail_nxt;
  logic [31:0]     fixc_r, fixc_nxt;
  logic [31:0]     charc_r, charc_nxt;
  logic [2:0]      status_r, status_nxt;
  logic            valid_r, valid_nxt;

  logic [7:0]      hi_ch, lo_ch, hex_hi, hex_lo, sum;

  assign q_pop = !q_stat.empty && (!valid_r || out_pop);

  assign hi_ch  = (fill_r != '0) ? chars_r[0] : 8'h00;
  assign lo_ch  = (fill_r > FW'(1)) ? chars_r[1] : 8'h00;
  assign hex_hi = nsf_pkg::hex_value(hi_ch);
  assign hex_lo = nsf_pkg::hex_value(lo_ch);
  assign sum    = {hex_hi[3:0], 4'h0} + hex_lo;

  always_comb begin
    xor_nxt    = xor_r;
    cs_nxt     = cs_r;
    kind_nxt   = kind_r;
    idx_nxt    = idx_r;
    fill_nxt   = fill_r;
    chars_nxt  = chars_r;
    fix_nxt    = fix_r;
    pass_nxt   = pass_r;
    fail_nxt   = fail_r;
    fixc_nxt   = fixc_r;
    charc_nxt  = charc_r;
    status_nxt = status_r;
    valid_nxt  = valid_r && !out_pop;
    if (q_pop) begin
      valid_nxt  = 1'b1;
      status_nxt = nsf_pkg::ST_NONE;
      charc_nxt  = charc_r + 32'd1;
      case (q_item.cls)
        nsf_pkg::CL_COMMA, nsf_pkg::CL_STAR, nsf_pkg::CL_EOL: begin
          if (q_item.cls == nsf_pkg::CL_COMMA) begin
            xor_nxt = xor_r ^ q_item.ch;
          end
          if (cs_r) begin
            if (sum == xor_nxt) begin
              pass_nxt   = pass_r + 32'd1;
              status_nxt = kind_r;
              if (fix_r) begin
                fixc_nxt = fixc_r + 32'd1;
              end
            end else begin
              fail_nxt   = fail_r + 32'd1;
              status_nxt = nsf_pkg::ST_FAIL;
            end
          end else if (idx_r == 8'd0) begin
            kind_nxt = (fill_r == FW'(nsf_pkg::NAME_LEN)) ?
                       nsf_pkg::name_kind(chars_r) : nsf_pkg::ST_NONE;
          end else if (fill_r != '0) begin
            if (kind_r == nsf_pkg::ST_RMC && idx_r == 8'd2) begin
              fix_nxt = (chars_r[0] == nsf_pkg::CH_FIX);
            end else if (kind_r == nsf_pkg::ST_GGA && idx_r == 8'd6) begin
              fix_nxt = (chars_r[0] > nsf_pkg::CH_ZERO);
            end
          end
          if (idx_r != 8'hFF) begin
            idx_nxt = idx_r + 8'd1;
          end
          fill_nxt = '0;
          cs_nxt   = (q_item.cls == nsf_pkg::CL_STAR);
        end
        nsf_pkg::CL_START: begin
          idx_nxt  = 8'd0;
          fill_nxt = '0;
          xor_nxt  = 8'h00;
          kind_nxt = nsf_pkg::ST_NONE;
          cs_nxt   = 1'b0;
          fix_nxt  = 1'b0;
        end
        default: begin
          if (fill_r < FW'(TERM_CHARS - 1)) begin
            if (fill_r < FW'(nsf_pkg::NAME_LEN)) begin
              chars_nxt[fill_r[2:0]] = q_item.ch;
            end
            fill_nxt = fill_r + FW'(1);
          end
          if (!cs_r) begin
            xor_nxt = xor_r ^ q_item.ch;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xor_r   <= 8'h00;
      cs_r    <= 1'b0;
      kind_r  <= nsf_pkg::ST_NONE;
      idx_r   <= 8'd0;
      fill_r  <= '0;
      fix_r   <= 1'b0;
      pass_r  <= 32'd0;
      fail_r  <= 32'd0;
      fixc_r  <= 32'd0;
      charc_r <= 32'd0;
      valid_r <= 1'b0;
    end else begin
      xor_r   <= xor_nxt;
      cs_r    <= cs_nxt;
      kind_r  <= kind_nxt;
      idx_r   <= idx_nxt;
      fill_r  <= fill_nxt;
      fix_r   <= fix_nxt;
      pass_r  <= pass_nxt;
      fail_r  <= fail_nxt;
      fixc_r  <= fixc_nxt;
      charc_r <= charc_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chars_r  <= chars_nxt;
    status_r <= status_nxt;
  end

  assign out_empty        = !valid_r;
  assign out_status       = status_r;
  assign out_has_fix      = fix_r;
  assign out_passed_count = pass_r;
  assign out_failed_count = fail_r;
  assign out_fix_count    = fixc_r;
  assign out_char_count   = charc_r;

endmodule

FILE: rtl/nmea_sentence_framer_unit.sv
// ---------------------------------------------------------------------------
// nmea_sentence_framer_unit
// Frames NMEA 0183 sentences one character at a time, checks the XOR
// checksum, tracks sentence type and fix, and keeps wrapping counters.
//
//   channel  ports                          transfer when
//   input    in_push in_full in_ch          in_push && !in_full
//   result   out_pop out_empty out_*        out_pop && !out_empty
//
// One result per character; one character per cycle while results are popped.
// A transfer writes the character into the queue; the back part then pops it
// and updates state into the result slot once that slot is free or popped.
// The result slot frees on the same cycle it is popped, so the back part
// keeps pace; stalls on the result side fill the queue and raise in_full.
// Sync active-low reset clears counters and state except chars_r, status_r.
// ---------------------------------------------------------------------------
module nmea_sentence_framer_unit #(
  parameter int TERM_CHARS  = nsf_pkg::TERM_CHARS_DEF,
  parameter int QUEUE_DEPTH = nsf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_ch,
  input  logic        out_pop,
  output logic        out_empty,
  output logic [2:0]  out_status,
  output logic        out_has_fix,
  output logic [31:0] out_passed_count,
  output logic [31:0] out_failed_count,
  output logic [31:0] out_fix_count,
  output logic [31:0] out_char_count
);

  nsf_pkg::q_stat_t q_stat;
  nsf_pkg::item_t   wr_item, rd_item;
  logic             q_push, q_pop;

  nsf_front u_front (
    .in_push (in_push),
    .in_ch   (in_ch),
    .q_stat  (q_stat),
    .in_full (in_full),
    .q_push  (q_push),
    .q_item  (wr_item)
  );

  nsf_queue #(
    .WIDTH ($bits(nsf_pkg::item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (wr_item),
    .pop     (q_pop),
    .rd_data (rd_item),
    .q_stat  (q_stat)
  );

  nsf_back #(
    .TERM_CHARS (TERM_CHARS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_stat           (q_stat),
    .q_item           (rd_item),
    .q_pop            (q_pop),
    .out_pop          (out_pop),
    .out_empty        (out_empty),
    .out_status       (out_status),
    .out_has_fix      (out_has_fix),
    .out_passed_count (out_passed_count),
    .out_failed_count (out_failed_count),
    .out_fix_count    (out_fix_count),
    .out_char_count   (out_char_count)
  );

  a_char_step: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && q_pop) |=> (out_char_count == $past(out_char_count) + 32'd1))
    else $error("char count did not advance by one on transfer");

  a_fail_status: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && q_pop) |=>
      ((out_failed_count != $past(out_failed_count)) ==
       (out_status == nsf_pkg::ST_FAIL)))
    else $error("failed count and status disagree");

  a_slot_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !out_empty && out_pop && q_stat.empty) |=> out_empty)
    else $error("result slot not freed after pop");

  a_no_idle_take: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |-> !q_pop)
    else $error("back part advanced over a waiting result");

endmodule
